/* sv/tccw_pkg.sv */
// shared types, constants and the latin-1 to cp437 remap for the console writer
// no dependencies; used by tccw_step and text_console_char_writer_top

package tccw_pkg;

    // screen geometry
    localparam int COLS = 80;
    localparam int ROWS = 50;

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = 12;
    localparam int CHR_W  = 8;
    localparam int ATTR_W = 8;
    localparam int WORD_W = 16;

    // column held one bit wider so tab and advance can reach cols before wrap
    localparam int COLX_W = COL_W + 1;
    // full product width before the address keeps its low bits
    localparam int PROD_W = COL_W + ROW_W + 1;

    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLS - 1);
    localparam logic [COLX_W-1:0] COL_LIMIT = COLX_W'(COLS);
    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(ROWS);

    // operation codes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    // control characters after remap
    localparam logic [CHR_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [CHR_W-1:0] CHR_BS    = 8'h08;
    localparam logic [CHR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHR_W-1:0] CHR_LF    = 8'h0A;
    localparam logic [CHR_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CHR_W-1:0] CHR_SPACE = 8'h20;

    localparam logic [COLX_W-1:0] TAB_STEP = COLX_W'(8);
    localparam logic [COLX_W-1:0] TAB_MASK = ~COLX_W'(7);

    typedef struct packed {
        logic              operation;
        logic [CHR_W-1:0]  char_code;
        logic [ATTR_W-1:0] attribute;
        logic [COL_W-1:0]  set_column;
        logic [ROW_W-1:0]  set_row;
    } t_item;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [WORD_W-1:0] write_word;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              off_screen;
    } t_result;

    // latin-1 to cp437 remap, other bytes pass unchanged
    function automatic logic [CHR_W-1:0] to_cp437(input logic [CHR_W-1:0] b);
        logic [CHR_W-1:0] r;
        case (b)
            8'hE4:   r = 8'h84;
            8'hF6:   r = 8'h94;
            8'hFC:   r = 8'h81;
            8'hDF:   r = 8'hE1;
            8'hA7:   r = 8'h15;
            8'hB0:   r = 8'hF8;
            8'hC4:   r = 8'h8E;
            8'hD6:   r = 8'h99;
            8'hDC:   r = 8'h9A;
            8'hB2:   r = 8'hFD;
            8'hB3:   r = 8'h00;
            8'h80:   r = 8'hEE;
            8'hB5:   r = 8'hE6;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

/* sv/tccw_step.sv */
// one item of cursor update and cell write decode, purely combinational
// depends on tccw_pkg

module tccw_step (
    input  tccw_pkg::t_item               i_item,
    input  logic [tccw_pkg::COL_W-1:0]    i_col,
    input  logic [tccw_pkg::ROW_W-1:0]    i_row,
    output tccw_pkg::t_result             o_res,
    output logic [tccw_pkg::COL_W-1:0]    o_col,
    output logic [tccw_pkg::ROW_W-1:0]    o_row
);

    always_comb begin
        logic [tccw_pkg::CHR_W-1:0]  uc;
        logic [tccw_pkg::COLX_W-1:0] col;
        logic [tccw_pkg::ROW_W-1:0]  row;
        logic                        do_wr;
        logic [tccw_pkg::COL_W-1:0]  wcol;
        logic [tccw_pkg::ROW_W-1:0]  wrow;
        logic [tccw_pkg::CHR_W-1:0]  wcode;
        logic [tccw_pkg::PROD_W-1:0] addr_full;

        uc    = tccw_pkg::to_cp437(i_item.char_code);
        col   = {1'b0, i_col};
        row   = i_row;
        do_wr = 1'b0;
        wcol  = '0;
        wrow  = '0;
        wcode = '0;

        if (i_item.operation == tccw_pkg::OP_PLACE) begin
            col = {1'b0, (i_item.set_column > tccw_pkg::COL_MAX) ?
                         tccw_pkg::COL_MAX : i_item.set_column};
            row = (i_item.set_row > tccw_pkg::ROW_LIMIT) ?
                  tccw_pkg::ROW_LIMIT : i_item.set_row;
        end else begin
            case (uc)
                tccw_pkg::CHR_BS: begin
                    // step back, crossing onto the previous line at column 0
                    if (col != '0) begin
                        col   = col - 1'b1;
                        do_wr = 1'b1;
                    end else if (row != '0) begin
                        col   = {1'b0, tccw_pkg::COL_MAX};
                        row   = row - 1'b1;
                        do_wr = 1'b1;
                    end
                    wcol  = col[tccw_pkg::COL_W-1:0];
                    wrow  = row;
                    wcode = tccw_pkg::CHR_SPACE;
                end
                tccw_pkg::CHR_TAB: begin
                    col = (col + tccw_pkg::TAB_STEP) & tccw_pkg::TAB_MASK;
                end
                tccw_pkg::CHR_CR: begin
                    col = '0;
                end
                tccw_pkg::CHR_LF: begin
                    col = '0;
                    if (row < tccw_pkg::ROW_LIMIT) begin
                        row = row + 1'b1;
                    end
                end
                default: begin
                    if (uc != tccw_pkg::CHR_NUL) begin
                        do_wr = 1'b1;
                        wcol  = col[tccw_pkg::COL_W-1:0];
                        wrow  = row;
                        wcode = uc;
                        col   = col + 1'b1;
                    end
                end
            endcase
            // line end wrap, row saturates one below the screen
            if (col >= tccw_pkg::COL_LIMIT) begin
                col = '0;
                if (row < tccw_pkg::ROW_LIMIT) begin
                    row = row + 1'b1;
                end
            end
        end

        addr_full = tccw_pkg::PROD_W'(wrow) * tccw_pkg::PROD_W'(tccw_pkg::COLS)
                  + tccw_pkg::PROD_W'(wcol);

        o_res = '0;
        if (do_wr) begin
            if (wrow >= tccw_pkg::ROW_LIMIT) begin
                o_res.off_screen = 1'b1;
            end else begin
                o_res.write_enable  = 1'b1;
                o_res.write_address = addr_full[tccw_pkg::ADDR_W-1:0];
                o_res.write_word    = {i_item.attribute, wcode};
            end
        end
        o_res.cursor_column = col[tccw_pkg::COL_W-1:0];
        o_res.cursor_row    = row;
        o_col = col[tccw_pkg::COL_W-1:0];
        o_row = row;
    end

endmodule

/* sv/text_console_char_writer_top.sv */
// text console writer top: input register, step logic, output register, cursor
// depends on tccw_pkg and tccw_step
//
//  channel   | dir | tdata fields (low bit up)                          | tuser
//  ----------+-----+----------------------------------------------------+----------
//  s_axis    | in  | char_code, attribute, set_column, set_row, pad    | operation
//  m_axis    | out | write_enable, write_address, write_word,          | -
//            |     | cursor_column, cursor_row, off_screen, pad        |
//
// the step logic is combinational; a result shows on m_axis once its item has passed
// the input and output registers; one item per cycle is taken unless m_axis stalls
// the only loop is the cursor register, updated when an item leaves the input stage
// reset (synchronous, active low) puts the cursor at column 0, row 0 and empties
// both stages; a stall on m_axis holds the output register, and the input stage
// still takes one more item before s_axis_tready drops

module text_console_char_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], attribute[15:8],
                                        // set_column[22:16], set_row[28:23], zero pad
    input  logic        s_axis_tuser,   // operation
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // write_enable[0], write_address[12:1],
                                        // write_word[28:13], cursor_column[35:29],
                                        // cursor_row[41:36], off_screen[42], zero pad
);

    // input stage
    logic                        r_in_valid;
    tccw_pkg::t_item             r_in_item;
    // output stage
    logic                        r_out_valid;
    tccw_pkg::t_result           r_out_res;
    // cursor
    logic [tccw_pkg::COL_W-1:0]  r_col;
    logic [tccw_pkg::ROW_W-1:0]  r_row;

    tccw_pkg::t_item             in_item;
    tccw_pkg::t_result           step_res;
    logic [tccw_pkg::COL_W-1:0]  n_col;
    logic [tccw_pkg::ROW_W-1:0]  n_row;
    logic                        advance;
    logic                        in_fire;

    // unpack the slave item
    always_comb begin
        in_item.operation  = s_axis_tuser;
        in_item.char_code  = s_axis_tdata[7:0];
        in_item.attribute  = s_axis_tdata[15:8];
        in_item.set_column = s_axis_tdata[22:16];
        in_item.set_row    = s_axis_tdata[28:23];
    end

    // the output register can load when empty or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    tccw_step u_step (
        .i_item (r_in_item),
        .i_col  (r_col),
        .i_row  (r_row),
        .o_res  (step_res),
        .o_col  (n_col),
        .o_row  (n_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_col       <= n_col;
                r_row       <= n_row;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0,
                            r_out_res.off_screen,
                            r_out_res.cursor_row,
                            r_out_res.cursor_column,
                            r_out_res.write_word,
                            r_out_res.write_address,
                            r_out_res.write_enable};

endmodule
